// File: src/merge_sort_engine_unit_defines.svh
// Assertion macros shared by the merge sort engine checkers.
`ifndef MERGE_SORT_ENGINE_UNIT_DEFINES_SVH
`define MERGE_SORT_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mse_pkg.sv
// Types and constants shared by the merge sort engine modules.
package mse_pkg;

    localparam int KEY_BITS          = 10;
    localparam int POS_BITS          = 6;
    localparam int MAX_ITEMS_DEFAULT = 64;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                is_last;
    } item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] sorted_key;
        logic [POS_BITS-1:0] source_position;
        logic                last_out;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [POS_BITS-1:0] pos;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN_START,
        ST_MERGE,
        ST_EMIT_START,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic run_start;
        logic merge_step;
        logic emit_start;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic tiny_set;
        logic run_end;
        logic sort_done;
        logic emit_end;
    } status_t;

endpackage

// File: src/mse_ctrl.sv
// Sequencer of the merge sort engine: load, merge passes, emit.
module mse_ctrl
    import mse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_beat,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    strobe
);

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && last_beat)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = status.tiny_set ? ST_EMIT_START : ST_RUN_START;
            end
            ST_RUN_START:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (status.run_end)
                begin
                    state_next = status.sort_done ? ST_EMIT_START : ST_RUN_START;
                end
            end
            ST_EMIT_START:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.emit_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Decode commands and port flags
    always_comb
    begin
        cmd    = '0;
        busy   = 1'b1;
        strobe = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_PREP:       cmd.prep       = 1'b1;
            ST_RUN_START:  cmd.run_start  = 1'b1;
            ST_MERGE:      cmd.merge_step = 1'b1;
            ST_EMIT_START: cmd.emit_start = 1'b1;
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                strobe        = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: src/mse_datapath.sv
// Key stores, ping-pong merge memories, run bookkeeping and compare.
module mse_datapath
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output status_t status,
    output result_t result
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = CNT_W + 2;

    // Two banks; each pass reads one and writes the other
    entry_t mem0 [DEPTH];
    entry_t mem1 [DEPTH];

    entry_t rd_a0_reg;
    entry_t rd_b0_reg;
    entry_t rd_a1_reg;
    entry_t rd_b1_reg;

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] width_reg;
    logic [SUM_W-1:0] lo_reg;
    logic [SUM_W-1:0] mid_reg;
    logic [SUM_W-1:0] hi_reg;
    logic [SUM_W-1:0] a_reg;
    logic [SUM_W-1:0] b_reg;
    logic [SUM_W-1:0] o_reg;
    logic             src_reg;

    logic [SUM_W-1:0] n_ext;
    logic [SUM_W-1:0] two_w;
    logic [SUM_W-1:0] lo_plus_w;
    logic [SUM_W-1:0] lo_plus_2w;
    logic [SUM_W-1:0] mid_calc;
    logic [SUM_W-1:0] hi_calc;
    logic [SUM_W-1:0] o_inc;
    logic             full;
    logic             pass_end;
    logic             sort_end;
    logic             take_a;
    entry_t           head_a;
    entry_t           head_b;
    entry_t           pick;
    entry_t           wr_entry;
    logic [SUM_W-1:0] wr_addr;
    logic             we0;
    logic             we1;
    logic [SUM_W-1:0] addr_a;
    logic [SUM_W-1:0] addr_b;

    // Run bounds and pass bookkeeping
    always_comb
    begin
        n_ext      = SUM_W'(count_reg);
        two_w      = width_reg << 1;
        lo_plus_w  = lo_reg + width_reg;
        lo_plus_2w = lo_reg + two_w;
        mid_calc   = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
        hi_calc    = (lo_plus_2w < n_ext) ? lo_plus_2w : n_ext;
        o_inc      = o_reg + SUM_W'(1);
        full       = (count_reg == CNT_W'(MAX_ITEMS));
        pass_end   = (lo_plus_2w >= n_ext);
        sort_end   = (two_w >= n_ext);
    end

    // Compare run heads; the left run wins a tie
    always_comb
    begin
        head_a = src_reg ? rd_a1_reg : rd_a0_reg;
        head_b = src_reg ? rd_b1_reg : rd_b0_reg;
        take_a = (a_reg < mid_reg) && ((b_reg >= hi_reg) || (head_a.key <= head_b.key));
        pick   = take_a ? head_a : head_b;
    end

    always_comb
    begin
        status.tiny_set  = (count_reg <= CNT_W'(1));
        status.run_end   = (o_inc == hi_reg);
        status.sort_done = (o_inc == hi_reg) && pass_end && sort_end;
        status.emit_end  = (o_inc == n_ext);
    end

    // Steer read addresses; prefetch the next head of the run that advances
    always_comb
    begin
        addr_a = a_reg;
        addr_b = b_reg;
        priority if (cmd.run_start)
        begin
            addr_a = lo_reg;
            addr_b = mid_calc;
        end
        else if (cmd.merge_step)
        begin
            addr_a = take_a ? a_reg + SUM_W'(1) : a_reg;
            addr_b = take_a ? b_reg : b_reg + SUM_W'(1);
        end
        else if (cmd.emit_start)
        begin
            addr_a = '0;
        end
        else if (cmd.emit_step)
        begin
            addr_a = o_inc;
        end
    end

    // Steer the write port: load beats go to bank 0, merges to the other bank
    always_comb
    begin
        we0      = 1'b0;
        we1      = 1'b0;
        wr_addr  = o_reg;
        wr_entry = pick;
        if (cmd.load)
        begin
            we0          = !full;
            wr_addr      = n_ext;
            wr_entry.key = item.key;
            wr_entry.pos = POS_BITS'(count_reg);
        end
        else if (cmd.merge_step)
        begin
            we0 = src_reg;
            we1 = !src_reg;
        end
    end

    // Bank 0
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[wr_addr[IDX_W-1:0]] <= wr_entry;
        end
        rd_a0_reg <= mem0[addr_a[IDX_W-1:0]];
        rd_b0_reg <= mem0[addr_b[IDX_W-1:0]];
    end

    // Bank 1
    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[wr_addr[IDX_W-1:0]] <= wr_entry;
        end
        rd_a1_reg <= mem1[addr_a[IDX_W-1:0]];
        rd_b1_reg <= mem1[addr_b[IDX_W-1:0]];
    end

    // Advance counters and run pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            o_reg     <= '0;
            src_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.prep)
            begin
                width_reg <= SUM_W'(1);
                lo_reg    <= '0;
                src_reg   <= 1'b0;
            end
            if (cmd.run_start)
            begin
                mid_reg <= mid_calc;
                hi_reg  <= hi_calc;
                a_reg   <= lo_reg;
                b_reg   <= mid_calc;
                o_reg   <= lo_reg;
            end
            if (cmd.merge_step)
            begin
                o_reg <= o_inc;
                if (take_a)
                begin
                    a_reg <= a_reg + SUM_W'(1);
                end
                else
                begin
                    b_reg <= b_reg + SUM_W'(1);
                end
                if (status.run_end)
                begin
                    if (pass_end)
                    begin
                        lo_reg    <= '0;
                        width_reg <= two_w;
                        src_reg   <= !src_reg;
                    end
                    else
                    begin
                        lo_reg <= lo_plus_2w;
                    end
                end
            end
            if (cmd.emit_start)
            begin
                o_reg <= '0;
            end
            if (cmd.emit_step)
            begin
                o_reg <= o_inc;
                if (status.emit_end)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    // Present the current head of the sorted bank
    always_comb
    begin
        result.sorted_key      = head_a.key;
        result.source_position = head_a.pos;
        result.last_out        = status.emit_end;
    end

endmodule

// File: src/merge_sort_engine_unit.sv
// Top level of the merge sort engine: sequencer plus datapath.
//
//  channel   handshake            payload    direction
//  --------  -------------------  ---------  ---------
//  load      start && !busy       item       in
//  result    strobe (no stall)    result     out
//
//  Each non-final key beat is taken while busy is low; busy stays low after it.
//  The final beat starts the sort: a PREP setup state, then ceil(log2 n) passes, each of
//  which opens every run with a RUN_START state before merging it, then EMIT_START and EMIT.
//  Within a run one element moves per cycle, set by the two read ports of the source bank.
//  Reset is asynchronous and clears control only; the banks need no clearing.
//  Results leave one per cycle with strobe high and cannot be held off.
module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    strobe,
    output result_t result
);

    cmd_t    cmd;
    status_t status;

    mse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_beat (item.is_last),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .strobe    (strobe)
    );

    mse_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// File: src/mse_checker.sv
// Port-level checks of the merge sort engine, bound to the top level.
`include "merge_sort_engine_unit_defines.svh"

module mse_checker
    import mse_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    strobe,
    input result_t result
);

    `MSE_ASSERT_NOW(a_strobe_busy, strobe, busy, "result beat while idle")
    `MSE_ASSERT_NEXT(a_plain_load_idle, start && !busy && !item.is_last, !busy && !strobe, "block left idle after a plain key beat")
    `MSE_ASSERT_NEXT(a_last_starts_sort, start && !busy && item.is_last, busy && !strobe, "final key beat did not start the sort")
    `MSE_ASSERT_NEXT(a_last_ends_run, strobe && result.last_out, !busy && !strobe, "block still busy after the final result beat")

endmodule

bind merge_sort_engine_unit mse_checker u_mse_checker (.*);
